// ===== rtl/core/pcs_pkg.sv =====
package pcs_pkg;

  localparam logic [7:0] PctChar = 8'h25;

  typedef enum logic [1:0] {
    HeldNone  = 2'd0,
    HeldPct   = 2'd1,
    HeldDigit = 2'd2
  } held_e;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } job_t;

  function automatic logic is_unreserved(input logic [7:0] c);
    logic res;
    res = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     8'h2D, 8'h5F, 8'h2E, 8'h7E});
    return res;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic res;
    res = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return res;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'd0, v};
    end else begin
      c = 8'h37 + {4'd0, v};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/pcs_front.sv =====
module pcs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_data_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          in_stall_o,
  output logic          push_o,
  output pcs_pkg::job_t job_o
);

  logic              mode_q;
  pcs_pkg::held_e    held_q, held_d;
  logic [7:0]        digit_q;
  logic              accept;
  logic              b_hex;
  logic              b_pct;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b_hex      = pcs_pkg::is_hex(in_byte_i);
  assign b_pct      = (in_byte_i == pcs_pkg::PctChar) && !in_last_i;

  always_comb begin
    job_o       = '0;
    job_o.last  = in_last_i;
    held_d      = pcs_pkg::HeldNone;
    if (!mode_q) begin
      if (pcs_pkg::is_unreserved(in_byte_i)) begin
        job_o.bytes[0] = in_byte_i;
        job_o.cnt      = 2'd1;
      end else begin
        job_o.bytes[0] = pcs_pkg::PctChar;
        job_o.bytes[1] = pcs_pkg::hex_upper(in_byte_i[7:4]);
        job_o.bytes[2] = pcs_pkg::hex_upper(in_byte_i[3:0]);
        job_o.cnt      = 2'd3;
      end
    end else begin
      case (held_q)
        pcs_pkg::HeldPct: begin
          if (b_hex && !in_last_i) begin
            held_d = pcs_pkg::HeldDigit;
          end else if (b_pct) begin
            job_o.bytes[0] = pcs_pkg::PctChar;
            job_o.cnt      = 2'd1;
            held_d         = pcs_pkg::HeldPct;
          end else begin
            job_o.bytes[0] = pcs_pkg::PctChar;
            job_o.bytes[1] = in_byte_i;
            job_o.cnt      = 2'd2;
          end
        end
        pcs_pkg::HeldDigit: begin
          if (b_hex) begin
            job_o.bytes[0] = {pcs_pkg::hex_nibble(digit_q), pcs_pkg::hex_nibble(in_byte_i)};
            job_o.cnt      = 2'd1;
          end else if (b_pct) begin
            job_o.bytes[0] = pcs_pkg::PctChar;
            job_o.bytes[1] = digit_q;
            job_o.cnt      = 2'd2;
            held_d         = pcs_pkg::HeldPct;
          end else begin
            job_o.bytes[0] = pcs_pkg::PctChar;
            job_o.bytes[1] = digit_q;
            job_o.bytes[2] = in_byte_i;
            job_o.cnt      = 2'd3;
          end
        end
        default: begin
          if (b_pct) begin
            held_d = pcs_pkg::HeldPct;
          end else begin
            job_o.bytes[0] = in_byte_i;
            job_o.cnt      = 2'd1;
          end
        end
      endcase
    end
  end

  assign push_o = accept && (job_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      held_q <= pcs_pkg::HeldNone;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
      held_q <= pcs_pkg::HeldNone;
    end else if (accept) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_d == pcs_pkg::HeldDigit) begin
      digit_q <= in_byte_i;
    end
  end

endmodule

// ===== rtl/core/pcs_queue.sv =====
module pcs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output pcs_pkg::job_t job_o,
  output logic          empty_o
);

  pcs_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/pcs_back.sv =====
module pcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcs_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          run_end_o,
  output logic          stream_end_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_end_q, stream_end_q;
  logic [1:0] idx_q;
  logic       load;
  logic       fin;

  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign fin   = (idx_q == (job_i.cnt - 2'd1));
  assign pop_o = load && fin;

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_end_q;
  assign stream_end_o = stream_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q       <= job_i.bytes[idx_q];
      run_end_q    <= fin;
      stream_end_q <= fin && job_i.last;
    end
  end

endmodule

// ===== rtl/core/percent_codec_stream_unit.sv =====
// The first result byte of an accepted request passes through a queue entry, then the output register.
// Throughput: one result byte per cycle from the single output register while not stalled;
// a request yields 1 to 3 bytes (its result count); a request with no result pushes no job.
// A two-entry queue between classifier and serializer absorbs output stalls.
// Reset (async, active low) selects encode mode, drops any held escape and empties the queue.
module percent_codec_stream_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       stream_end_o
);

  pcs_pkg::job_t job_in, job_out;
  logic          push, pop, full, empty;

  pcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (job_in)
  );

  pcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  pcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

endmodule

// ===== dv/tb_percent_codec_stream_unit.sv =====
`timescale 1ns / 1ps

module tb_percent_codec_stream_unit;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;
  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } codec_result_t;

  typedef enum logic [1:0] {
    StallNone,
    StallCoin,
    StallHeavy,
    StallPeriodic
  } stall_style_e;

  class codec_scoreboard;
    logic           decode_mode;
    pcs_pkg::held_e held;
    logic [7:0]     held_char;
    logic [7:0]     run_bytes[$];
    codec_result_t  expected_q[$];
    int             mismatches;

    function new();
      decode_mode = ModeEncode;
      held = pcs_pkg::HeldNone;
      held_char = 8'h00;
      mismatches = 0;
    endfunction

    function void set_mode(logic m);
      decode_mode = m;
      held = pcs_pkg::HeldNone;
      held_char = 8'h00;
    endfunction

    // {is_hex, nibble}
    function logic [4:0] hex_lookup(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        return {1'b1, 4'(c[3:0] + 4'd9)};
      return 5'd0;
    endfunction

    function logic passes_unescaped(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F ||
             c == 8'h2E || c == 8'h7E;
    endfunction

    function logic [7:0] upper_digit(logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    function void take_plain(logic [7:0] b, logic last);
      if (b == pcs_pkg::PctChar && !last) begin
        held = pcs_pkg::HeldPct;
      end else begin
        run_bytes.push_back(b);
      end
    endfunction

    function void note_request(logic [7:0] b, logic last);
      pcs_pkg::held_e prev;
      logic [4:0]     hi;
      logic [4:0]     lo;
      prev = held;
      held = pcs_pkg::HeldNone;
      run_bytes.delete();
      lo = hex_lookup(b);
      if (decode_mode == ModeEncode) begin
        if (passes_unescaped(b)) begin
          run_bytes.push_back(b);
        end else begin
          run_bytes.push_back(pcs_pkg::PctChar);
          run_bytes.push_back(upper_digit(b[7:4]));
          run_bytes.push_back(upper_digit(b[3:0]));
        end
      end else if (prev == pcs_pkg::HeldPct) begin
        if (lo[4] && !last) begin
          held = pcs_pkg::HeldDigit;
          held_char = b;
        end else begin
          run_bytes.push_back(pcs_pkg::PctChar);
          take_plain(b, last);
        end
      end else if (prev == pcs_pkg::HeldDigit) begin
        hi = hex_lookup(held_char);
        if (hi[4] && lo[4]) begin
          run_bytes.push_back({hi[3:0], lo[3:0]});
        end else begin
          run_bytes.push_back(pcs_pkg::PctChar);
          run_bytes.push_back(held_char);
          take_plain(b, last);
        end
      end else begin
        take_plain(b, last);
      end
      if (held != pcs_pkg::HeldDigit) held_char = 8'h00;
      foreach (run_bytes[k]) begin
        expected_q.push_back('{data: run_bytes[k],
                               run_end: (k == run_bytes.size() - 1),
                               stream_end: (k == run_bytes.size() - 1) && last});
      end
    endfunction

    function void check_result(logic [7:0] data, logic run_end, logic stream_end);
      codec_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte %02h run_end %0b stream_end %0b",
               data, run_end, stream_end);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (run_end !== want.run_end) begin
        $error("run_end: expected %0b, got %0b", want.run_end, run_end);
        mismatches++;
      end
      if (stream_end !== want.stream_end) begin
        $error("stream_end: expected %0b, got %0b", want.stream_end, stream_end);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       run_end_o;
  logic       stream_end_o;

  codec_scoreboard model;
  int           burst_left;
  int           idle_cycles;
  int           stall_left;
  stall_style_e stall_style;

  percent_codec_stream_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .stream_end_o(stream_end_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_style)
      StallNone:     out_stall_i <= 1'b0;
      StallCoin:     out_stall_i <= 1'($urandom_range(0, 1));
      StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall_i <= (stall_left % 3 == 0);
      default:       out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      model.check_result(out_byte_o, run_end_o, stream_end_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    model.note_request(b, last);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (model.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.set_mode(m);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? 8'h57 : 8'h37) + 8'(v);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(0, 255));
      h = model.hex_lookup(c);
    end while (h[4]);
    return c;
  endfunction

  task automatic encode_phase(int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h2D, 8'h7E));
      send_request(b, $urandom_range(0, 7) == 0);
    end
  endtask

  // well-formed escapes as the most common token kind, plus broken and truncated ones and noise
  task automatic decode_phase(int count);
    int         sent;
    int         kind;
    logic       end_stream;
    logic [7:0] tok[$];
    sent = 0;
    while (sent < count) begin
      tok.delete();
      kind = $urandom_range(0, 9);
      end_stream = ($urandom_range(0, 7) == 0);
      case (kind)
        0, 1, 2, 3: tok = '{pcs_pkg::PctChar, rand_hex_char(), rand_hex_char()};
        4: tok = '{8'($urandom_range(8'h20, 8'h7E))};
        5: tok = '{pcs_pkg::PctChar, non_hex_char()};
        6: tok = '{pcs_pkg::PctChar, rand_hex_char(),
                   ($urandom_range(0, 1) == 1) ? pcs_pkg::PctChar : non_hex_char()};
        7: begin
          tok = '{pcs_pkg::PctChar};
          if ($urandom_range(0, 1) == 1) tok.push_back(rand_hex_char());
          end_stream = 1'b1;
        end
        8: tok = '{8'($urandom_range(0, 255))};
        default: tok = '{pcs_pkg::PctChar, pcs_pkg::PctChar};
      endcase
      foreach (tok[i]) begin
        send_request(tok[i], end_stream && (i == tok.size() - 1));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] enc_dir[] = '{8'h00, 8'hFF, 8'h5A, 8'h61, 8'h39, 8'h2D, 8'h7E, 8'h25};
    string      dec_stream;
    logic       modes[6] = '{ModeDecode, ModeEncode, ModeDecode, ModeDecode,
                             ModeEncode, ModeDecode};

    model = new();
    burst_left = 0;
    idle_cycles = 0;
    stall_left = 0;
    stall_style = StallNone;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = 8'h00;
    in_last_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(ModeEncode);
    foreach (enc_dir[i]) send_request(enc_dir[i], i == enc_dir.size() - 1);
    finish_phase();

    // valid escapes, bad first/second digit, re-scanned '%', flushes at end
    write_mode(ModeDecode);
    dec_stream = "%41%af%G%4%2E%5";
    for (int i = 0; i < dec_stream.len(); i++) begin
      send_request(dec_stream[i], i == dec_stream.len() - 1);
    end
    send_request(pcs_pkg::PctChar, 1'b1);
    send_request(pcs_pkg::PctChar, 1'b0);
    send_request(8'h34, 1'b0);
    send_request(8'h7E, 1'b1);
    finish_phase();

    foreach (modes[p]) begin
      write_mode(modes[p]);
      if (modes[p] == ModeDecode) decode_phase(45);
      else encode_phase(30);
      finish_phase();
    end

    if (model.mismatches == 0 && model.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
